>>> hdl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;

    // Result word kinds
    localparam logic [1:0] K_PAYLOAD = 2'd0;
    localparam logic [1:0] K_GOOD    = 2'd1;
    localparam logic [1:0] K_BADSUM  = 2'd2;
    localparam logic [1:0] K_HDRERR  = 2'd3;

    // Reply requests
    localparam logic [1:0] REPLY_NONE      = 2'd0;
    localparam logic [1:0] REPLY_HANDSHAKE = 2'd1;
    localparam logic [1:0] REPLY_TELEMETRY = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HDR2 = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_length;
        logic [1:0]  reply_request;
        logic        handshake_done;
        logic [31:0] error_total;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } parse_out_t;

endpackage

`default_nettype wire

>>> hdl/slcd_if.sv
// ----------------------------------------------------------------------------
// slcd_if
// Valid/ready channels of the deframer: received bytes in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface slcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
    logic [1:0]  reply_request;
    logic        handshake_done;
    logic [31:0] error_total;

    modport source (
        output valid, output kind, output data_byte, output byte_index,
        output frame_length, output reply_request, output handshake_done,
        output error_total, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input byte_index,
        input frame_length, input reply_request, input handshake_done,
        input error_total, output ready
    );
endinterface

`default_nettype wire

>>> hdl/slcd_in_stage.sv
// ----------------------------------------------------------------------------
// slcd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_in_stage
    import slcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    slcd_in_if.sink    rx,
    input  wire logic  advance,
    output logic       valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       fire;

    // Take a new word when empty or when the held one leaves in this cycle
    assign rx.ready = !valid_reg || advance;
    assign fire     = rx.valid && rx.ready;

    always_comb
    begin
        if (fire)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            byte_reg <= rx.rx_byte;
    end

    assign valid   = valid_reg;
    assign rx_byte = byte_reg;

endmodule

`default_nettype wire

>>> hdl/slcd_parser.sv
// ----------------------------------------------------------------------------
// slcd_parser
// Frame state machine with running checksum, error counter and handshake
// latch; builds the result word for the byte it is given.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_parser
    import slcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire logic [7:0] rx_byte,
    output parse_out_t po
);

    phase_t      phase_reg,  phase_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  cnt_reg,    cnt_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [7:0]  first_reg,  first_next;
    logic [31:0] err_reg,    err_next;
    logic        hs_reg,     hs_next;

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        err_next   = err_reg;
        hs_next    = hs_reg;
        case (phase_reg)
            PH_HDR2:
            begin
                if (rx_byte == HDR_SECOND)
                    phase_next = PH_LEN;
                else
                begin
                    err_next   = err_reg + 32'd1;
                    phase_next = PH_HUNT;
                    len_next   = '0;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
            end
            PH_LEN:
            begin
                len_next   = rx_byte;
                cnt_next   = '0;
                sum_next   = rx_byte;
                phase_next = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                if (cnt_reg == 8'd0)
                    first_next = rx_byte;
                sum_next = sum_reg + rx_byte;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_next >= len_reg)
                    phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                if (sum_reg == rx_byte)
                begin
                    if (len_reg == 8'd1 && first_reg == 8'd1)
                        hs_next = 1'b1;
                end
                else
                    err_next = err_reg + 32'd1;
                phase_next = PH_HUNT;
                len_next   = '0;
                cnt_next   = '0;
                sum_next   = '0;
            end
            default:
            begin
                // Hunt; unused codes behave the same
                phase_next = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    end

    // Result word
    always_comb
    begin
        po.emit                  = 1'b0;
        po.res.kind              = K_PAYLOAD;
        po.res.data_byte         = '0;
        po.res.byte_index        = '0;
        po.res.frame_length      = '0;
        po.res.reply_request     = REPLY_NONE;
        po.res.handshake_done    = hs_next;
        po.res.error_total       = err_next;
        case (phase_reg)
            PH_HDR2:
            begin
                if (rx_byte != HDR_SECOND)
                begin
                    po.emit     = 1'b1;
                    po.res.kind = K_HDRERR;
                end
            end
            PH_DATA:
            begin
                po.emit             = 1'b1;
                po.res.kind         = K_PAYLOAD;
                po.res.data_byte    = rx_byte;
                po.res.byte_index   = cnt_reg;
                po.res.frame_length = len_reg;
            end
            PH_SUM:
            begin
                po.emit             = 1'b1;
                po.res.frame_length = len_reg;
                if (sum_reg == rx_byte)
                begin
                    po.res.kind = K_GOOD;
                    if (len_reg == 8'd1 && first_reg == 8'd1)
                        po.res.reply_request = REPLY_HANDSHAKE;
                    else
                        po.res.reply_request = REPLY_TELEMETRY;
                end
                else
                    po.res.kind = K_BADSUM;
            end
            default:
            begin
                po.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            first_reg <= '0;
            err_reg   <= '0;
            hs_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            first_reg <= first_next;
            err_reg   <= err_next;
            hs_reg    <= hs_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/slcd_out_stage.sv
// ----------------------------------------------------------------------------
// slcd_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_out_stage
    import slcd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res_in,
    output logic         free,
    slcd_out_if.source   res
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Room for a new word when empty or the held one leaves now
    assign free = !valid_reg || res.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign res.valid          = valid_reg;
    assign res.kind           = data_reg.kind;
    assign res.data_byte      = data_reg.data_byte;
    assign res.byte_index     = data_reg.byte_index;
    assign res.frame_length   = data_reg.frame_length;
    assign res.reply_request  = data_reg.reply_request;
    assign res.handshake_done = data_reg.handshake_done;
    assign res.error_total    = data_reg.error_total;

endmodule

`default_nettype wire

>>> hdl/sync_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Parses 0x55, 0xAA, length, payload, checksum frames from a byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while the result sink is
// ready. A byte passes an input register, the parser state machine and a
// result register. Its result word is loaded into the result register when
// the parser steps on the held byte, waiting while that register is full.
// Bytes in hunt, a good second header byte and the length byte give no
// result word; each payload byte gives one word with its index, the checksum
// byte gives the verdict, and a wrong second header byte gives a header
// error word. The rate is set by the parser state update; the block only
// slows down when the result sink holds off ready.
`default_nettype none

module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    slcd_in_if.sink    rx,
    slcd_out_if.source res
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_free;
    logic       step;
    parse_out_t po;

    // Consume the held byte unless its result word has nowhere to go
    assign step = held_valid && (!po.emit || out_free);

    slcd_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (step),
        .valid   (held_valid),
        .rx_byte (held_byte)
    );

    slcd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (held_byte),
        .po      (po)
    );

    slcd_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step && po.emit),
        .res_in (po.res),
        .free   (out_free),
        .res    (res)
    );

endmodule

`default_nettype wire
